/* hdl/core_load_balance_decider_assert.svh */
`ifndef CORE_LOAD_BALANCE_DECIDER_ASSERT_SVH
`define CORE_LOAD_BALANCE_DECIDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset.
`define CLBD_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/clbd_pkg.sv */
package clbd_pkg;

  localparam int NUM_CORES_DEF      = 8;
  localparam int THREAD_ID_BITS_DEF = 8;

  localparam int KIND_W     = 2;
  localparam int CORE_W     = 3;
  localparam int COUNT_W    = 64;
  localparam int TID_W      = 8;
  localparam int ACTIVE_W   = 4;
  localparam int INTERVAL_W = 32;
  localparam int PCT_W      = 7;
  localparam int QUO_W      = 7;
  localparam int NUM_W      = INTERVAL_W + QUO_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [PCT_W-1:0]      PCT_FULL     = 7'd100;
  localparam logic [PCT_W-1:0]      RST_HIGH_THR = 7'd75;
  localparam logic [PCT_W-1:0]      RST_LOW_THR  = 7'd25;
  localparam logic [ACTIVE_W-1:0]   RST_ACTIVE   = 4'd8;
  localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 32'd100000;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVAL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OFFER  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW      = 3'd4;

  localparam logic REPORT_EVAL = 1'b0;
  localparam logic REPORT_END  = 1'b1;

  typedef struct packed {
    logic                  enable;
    logic [ACTIVE_W-1:0]   active_cores;
    logic [INTERVAL_W-1:0] interval;
    logic [PCT_W-1:0]      high_thr;
    logic [PCT_W-1:0]      low_thr;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CORE_W-1:0]  core;
    logic [COUNT_W-1:0] value;
    logic [TID_W-1:0]   tid;
    logic               excl;
  } cmd_t;

  typedef struct packed {
    logic              report_kind;
    logic              balance_needed;
    logic [CORE_W-1:0] busy_core;
    logic [CORE_W-1:0] idle_core;
    logic              migrate;
    logic [TID_W-1:0]  chosen_thread;
  } res_t;

  typedef struct packed {
    logic                  go;
    logic [NUM_W-1:0]      num;
    logic [INTERVAL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

/* hdl/clbd_front.sv */
module clbd_front import clbd_pkg::*; #(
  parameter int NUM_CORES = NUM_CORES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_enable,
  input  logic               in_push,
  output logic               in_full,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [CORE_W-1:0]  in_core_index,
  input  logic [COUNT_W-1:0] in_idle_count,
  input  logic [TID_W-1:0]   in_thread_id,
  input  logic [COUNT_W-1:0] in_run_count,
  input  logic               in_excluded,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cmd_t               cmd
);

  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = 1;

  cmd_t             q_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r;
  logic [CQ_AW-1:0] rd_ptr_r;
  logic [CQ_AW:0]   cnt_r;
  logic             accept;
  logic             keep;
  logic             pop;
  cmd_t             cmd_in;

  // Beats that can never change state or give a result are dropped here.
  assign accept = in_push && !in_full;
  assign keep   = accept && cfg_enable &&
                  !(in_kind == KIND_SAMPLE && 32'(in_core_index) >= 32'(NUM_CORES));
  assign pop    = cmd_valid && cmd_ready;

  always_comb begin
    cmd_in.kind  = in_kind;
    cmd_in.core  = in_core_index;
    cmd_in.value = (in_kind == KIND_SAMPLE) ? in_idle_count : in_run_count;
    cmd_in.tid   = in_thread_id;
    cmd_in.excl  = in_excluded;
  end

  assign in_full   = (cnt_r == (CQ_AW+1)'(CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (keep) begin
        wr_ptr_r <= wr_ptr_r + CQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + CQ_AW'(1);
      end
      if (keep && !pop) begin
        cnt_r <= cnt_r + (CQ_AW+1)'(1);
      end else if (pop && !keep) begin
        cnt_r <= cnt_r - (CQ_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* hdl/clbd_div.sv */
module clbd_div import clbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(QUO_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic             ge;

  // Restoring division, one quotient bit per cycle, most significant first.
  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem_r <= req.num;
      dsh_r <= NUM_W'(req.den) << (QUO_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

/* hdl/clbd_back.sv */
module clbd_back import clbd_pkg::*; #(
  parameter int NUM_CORES      = NUM_CORES_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  cmd_t     cmd,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  output logic     out_empty,
  input  logic     out_pop,
  output res_t     res
);

  localparam int CIW   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int CNT_W = $clog2(NUM_CORES + 1);
  localparam int TIDW  = THREAD_ID_BITS;
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELTA = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_EVAL  = 3'd6;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic [COUNT_W-1:0] last_idle_r [NUM_CORES];
  logic [PCT_W-1:0]   load_r [NUM_CORES];
  logic               scan_active_r;
  logic [CIW-1:0]     busy_sel_r;
  logic [CIW-1:0]     idle_sel_r;
  logic [COUNT_W-1:0] best_count_r;
  logic [TIDW-1:0]    best_thread_r;
  logic               best_found_r;

  logic [CIW-1:0]     cur_core_r;
  logic [COUNT_W-1:0] cur_value_r;
  logic [COUNT_W-1:0] delta_r;
  logic [NUM_W-1:0]   prod_r;

  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   n_r;
  logic [PCT_W-1:0]   max_load_r;
  logic [PCT_W-1:0]   min_load_r;
  logic [CIW-1:0]     max_i_r;
  logic [CIW-1:0]     min_i_r;
  logic               max_ok_r;
  logic               min_ok_r;

  res_t               oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0]   oq_wr_r;
  logic [OQ_AW-1:0]   oq_rd_r;
  logic [OQ_AW:0]     oq_cnt_r;

  logic               oq_full;
  logic               fire;
  logic               push_end;
  logic               push_eval;
  logic               oq_push;
  logic               oq_pop;
  logic               offer_hit;
  logic               need;
  logic [PCT_W-1:0]   scan_load;
  logic [CNT_W-1:0]   n_cfg;
  res_t               res_in;

  assign oq_full   = (oq_cnt_r == (OQ_AW+1)'(OQ_DEPTH));
  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign res       = oq_r[oq_rd_r];

  assign cmd_ready = (state_r == S_IDLE) &&
                     !(cmd.kind == KIND_END && scan_active_r && oq_full);
  assign fire      = cmd_valid && cmd_ready;
  assign push_end  = fire && cmd.kind == KIND_END && scan_active_r;
  assign push_eval = (state_r == S_EVAL) && !oq_full;
  assign oq_push   = push_end || push_eval;

  assign offer_hit = scan_active_r && !cmd.excl &&
                     (32'(cmd.core) == 32'(busy_sel_r)) && (cmd.value > best_count_r);

  assign need = max_ok_r && min_ok_r && (max_i_r != min_i_r) &&
                (max_load_r >= cfg.high_thr) && (min_load_r <= cfg.low_thr);

  assign scan_load = load_r[idx_r[CIW-1:0]];
  assign n_cfg     = (32'(cfg.active_cores) > 32'(NUM_CORES)) ? CNT_W'(NUM_CORES)
                                                               : CNT_W'(cfg.active_cores);

  always_comb begin
    if (push_eval) begin
      res_in.report_kind    = REPORT_EVAL;
      res_in.balance_needed = need;
      res_in.busy_core      = CORE_W'(max_i_r);
      res_in.idle_core      = CORE_W'(min_i_r);
      res_in.migrate        = 1'b0;
      res_in.chosen_thread  = '0;
    end else begin
      res_in.report_kind    = REPORT_END;
      res_in.balance_needed = 1'b1;
      res_in.busy_core      = CORE_W'(busy_sel_r);
      res_in.idle_core      = CORE_W'(idle_sel_r);
      res_in.migrate        = best_found_r;
      res_in.chosen_thread  = best_found_r ? TID_W'(best_thread_r) : '0;
    end
  end

  always_comb begin
    div_req.go  = (state_r == S_DIVGO);
    div_req.num = prod_r;
    div_req.den = cfg.interval;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (fire && cmd.kind == KIND_SAMPLE) begin
          state_nxt = S_DELTA;
        end else if (fire && cmd.kind == KIND_EVAL) begin
          state_nxt = S_SCAN;
        end
      end
      S_DELTA: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (cfg.interval == '0 || delta_r >= COUNT_W'(cfg.interval)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (idx_r >= n_r) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!oq_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      scan_active_r <= 1'b0;
      busy_sel_r    <= '0;
      idle_sel_r    <= '0;
      best_count_r  <= '0;
      best_thread_r <= '0;
      best_found_r  <= 1'b0;
      oq_wr_r       <= '0;
      oq_rd_r       <= '0;
      oq_cnt_r      <= '0;
      for (int i = 0; i < NUM_CORES; i++) begin
        last_idle_r[i] <= '0;
        load_r[i]      <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (fire && cmd.kind == KIND_OFFER && offer_hit) begin
        best_count_r  <= cmd.value;
        best_thread_r <= TIDW'(cmd.tid);
        best_found_r  <= 1'b1;
      end
      if (push_end) begin
        scan_active_r <= 1'b0;
      end
      if (push_eval) begin
        busy_sel_r    <= max_i_r;
        idle_sel_r    <= min_i_r;
        scan_active_r <= need;
        best_count_r  <= '0;
        best_thread_r <= '0;
        best_found_r  <= 1'b0;
      end
      if (state_r == S_DELTA) begin
        last_idle_r[cur_core_r] <= cur_value_r;
      end
      if (state_r == S_MUL && cfg.interval != '0 &&
          delta_r >= COUNT_W'(cfg.interval)) begin
        load_r[cur_core_r] <= '0;
      end
      if (state_r == S_DIV && div_rsp.done) begin
        load_r[cur_core_r] <= PCT_FULL - div_rsp.quo;
      end
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + OQ_AW'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + (OQ_AW+1)'(1);
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - (OQ_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res_in;
    end
    if (fire && cmd.kind == KIND_SAMPLE) begin
      cur_core_r  <= CIW'(cmd.core);
      cur_value_r <= cmd.value;
    end
    if (state_r == S_DELTA) begin
      delta_r <= cur_value_r - last_idle_r[cur_core_r];
    end
    if (state_r == S_MUL) begin
      prod_r <= NUM_W'(delta_r[INTERVAL_W-1:0]) * NUM_W'(PCT_FULL);
    end
    if (fire && cmd.kind == KIND_EVAL) begin
      idx_r      <= '0;
      n_r        <= n_cfg;
      max_load_r <= '0;
      min_load_r <= PCT_FULL;
      max_i_r    <= '0;
      min_i_r    <= '0;
      max_ok_r   <= 1'b0;
      min_ok_r   <= 1'b0;
    end else if (state_r == S_SCAN && idx_r < n_r) begin
      idx_r <= idx_r + CNT_W'(1);
      if (scan_load > max_load_r) begin
        max_load_r <= scan_load;
        max_i_r    <= idx_r[CIW-1:0];
        max_ok_r   <= 1'b1;
      end
      if (scan_load < min_load_r) begin
        min_load_r <= scan_load;
        min_i_r    <= idx_r[CIW-1:0];
        min_ok_r   <= 1'b1;
      end
    end
  end

endmodule

/* hdl/core_load_balance_decider.sv */
// Channel   Ports                                        Handshake
// input     in_kind .. in_excluded                       in_push, in_full
// result    out_report_kind .. out_chosen_thread         out_pop, out_empty
// config    cfg_index, cfg_wdata                         cfg_wr_en
//
// An idle sample passes the delta, multiply, divider-start and serial divider states,
// or skips the divider when the interval is zero or the idle delta reaches the interval.
// An evaluate scans the active cores, at most NUM_CORES, one core per cycle.
// Thread offers and end-of-scan beats are taken in the idle state alone.
// A two-entry command queue and a two-entry result queue decouple both sides;
// an answer waits while the result queue is full.
// Reset is synchronous.
module core_load_balance_decider import clbd_pkg::*; #(
  parameter int NUM_CORES      = NUM_CORES_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [CORE_W-1:0]     in_core_index,
  input  logic [COUNT_W-1:0]    in_idle_count,
  input  logic [TID_W-1:0]      in_thread_id,
  input  logic [COUNT_W-1:0]    in_run_count,
  input  logic                  in_excluded,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_report_kind,
  output logic                  out_balance_needed,
  output logic [CORE_W-1:0]     out_busy_core,
  output logic [CORE_W-1:0]     out_idle_core,
  output logic                  out_migrate,
  output logic [TID_W-1:0]      out_chosen_thread,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg_r;
  logic     cmd_valid;
  logic     cmd_ready;
  cmd_t     cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= 1'b1;
      cfg_r.active_cores <= RST_ACTIVE;
      cfg_r.interval     <= RST_INTERVAL;
      cfg_r.high_thr     <= RST_HIGH_THR;
      cfg_r.low_thr      <= RST_LOW_THR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ENABLE:   cfg_r.enable       <= cfg_wdata[0];
        REG_ACTIVE:   cfg_r.active_cores <= cfg_wdata[ACTIVE_W-1:0];
        REG_INTERVAL: cfg_r.interval     <= cfg_wdata[INTERVAL_W-1:0];
        REG_HIGH:     cfg_r.high_thr     <= cfg_wdata[PCT_W-1:0];
        REG_LOW:      cfg_r.low_thr      <= cfg_wdata[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  clbd_front #(
    .NUM_CORES(NUM_CORES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_enable   (cfg_r.enable),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_kind      (in_kind),
    .in_core_index(in_core_index),
    .in_idle_count(in_idle_count),
    .in_thread_id (in_thread_id),
    .in_run_count (in_run_count),
    .in_excluded  (in_excluded),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  clbd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  clbd_back #(
    .NUM_CORES     (NUM_CORES),
    .THREAD_ID_BITS(THREAD_ID_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .res      (res)
  );

  assign out_report_kind    = res.report_kind;
  assign out_balance_needed = res.balance_needed;
  assign out_busy_core      = res.busy_core;
  assign out_idle_core      = res.idle_core;
  assign out_migrate        = res.migrate;
  assign out_chosen_thread  = res.chosen_thread;

endmodule

/* hdl/clbd_checker.sv */
`include "core_load_balance_decider_assert.svh"

module clbd_checker import clbd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic              out_report_kind,
  input logic              out_balance_needed,
  input logic [CORE_W-1:0] out_busy_core,
  input logic [CORE_W-1:0] out_idle_core,
  input logic              out_migrate,
  input logic [TID_W-1:0]  out_chosen_thread
);

  `CLBD_ASSERT_IMP(a_eval_no_migrate, clk, rst_n, !out_empty && out_report_kind == REPORT_EVAL, !out_migrate && out_chosen_thread == '0, "Evaluate beat carries a migration.")
  `CLBD_ASSERT_IMP(a_end_needs_balance, clk, rst_n, !out_empty && out_report_kind == REPORT_END, out_balance_needed, "End-of-scan beat without a balancing decision.")
  `CLBD_ASSERT_IMP(a_no_thread_without_migrate, clk, rst_n, !out_empty && !out_migrate, out_chosen_thread == '0, "Thread reported without a migration.")
  `CLBD_ASSERT_NXT_ALWAYS(a_reset_empties, clk, !rst_n, out_empty, "Result queue not empty after reset.")
  `CLBD_ASSERT_NXT(a_hold_result, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_report_kind) && $stable(out_busy_core) && $stable(out_idle_core) && $stable(out_chosen_thread), "Waiting result beat changed.")

endmodule

bind core_load_balance_decider clbd_checker u_clbd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_report_kind   (out_report_kind),
  .out_balance_needed(out_balance_needed),
  .out_busy_core     (out_busy_core),
  .out_idle_core     (out_idle_core),
  .out_migrate       (out_migrate),
  .out_chosen_thread (out_chosen_thread)
);

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import clbd_pkg::*;

  localparam int CORES         = NUM_CORES_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int LIMIT_NS      = 2_000_000;

  logic                  clk                = 1'b0;
  logic                  rst_n              = 1'b0;
  logic                  in_push            = 1'b0;
  logic                  in_full;
  logic [KIND_W-1:0]     in_kind            = KIND_SAMPLE;
  logic [CORE_W-1:0]     in_core_index      = '0;
  logic [COUNT_W-1:0]    in_idle_count      = '0;
  logic [TID_W-1:0]      in_thread_id       = '0;
  logic [COUNT_W-1:0]    in_run_count       = '0;
  logic                  in_excluded        = 1'b0;
  logic                  out_empty;
  logic                  out_pop            = 1'b0;
  logic                  out_report_kind;
  logic                  out_balance_needed;
  logic [CORE_W-1:0]     out_busy_core;
  logic [CORE_W-1:0]     out_idle_core;
  logic                  out_migrate;
  logic [TID_W-1:0]      out_chosen_thread;
  logic                  cfg_wr_en          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index          = REG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_wdata          = '0;

  core_load_balance_decider uut (.*);

  always #4 clk = ~clk;

  cfg_t               cfg_now;
  logic [COUNT_W-1:0] prev_idle [CORES];
  logic [PCT_W-1:0]   core_load [CORES];
  logic               scan_open;
  logic [CORE_W-1:0]  sel_busy;
  logic [CORE_W-1:0]  sel_idle;
  logic [COUNT_W-1:0] top_runs;
  logic [TID_W-1:0]   top_tid;
  logic               top_valid;
  res_t               decision_q [$];
  int                 errors      = 0;
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  int                 sent_count  = 0;

  function automatic logic [COUNT_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void predict_decision(input logic [KIND_W-1:0] kind,
      input logic [CORE_W-1:0] core, input logic [COUNT_W-1:0] idle,
      input logic [TID_W-1:0] tid, input logic [COUNT_W-1:0] runs, input logic excl);
    logic [COUNT_W-1:0] delta;
    logic [COUNT_W-1:0] quo;
    logic [PCT_W-1:0]   hi_load;
    logic [PCT_W-1:0]   lo_load;
    logic               hi_ok;
    logic               lo_ok;
    logic               need;
    int                 span;
    int                 hi_i;
    int                 lo_i;
    if (!cfg_now.enable) return;
    case (kind)
      KIND_SAMPLE: begin
        delta = idle - prev_idle[core];
        if (cfg_now.interval != 0) begin
          if (delta >= COUNT_W'(cfg_now.interval)) begin
            core_load[core] = '0;
          end else begin
            quo = (delta * 64'd100) / COUNT_W'(cfg_now.interval);
            core_load[core] = PCT_FULL - PCT_W'(quo);
          end
        end
        prev_idle[core] = idle;
      end
      KIND_EVAL: begin
        span = (cfg_now.active_cores > CORES) ? CORES : int'(cfg_now.active_cores);
        hi_load = '0;
        lo_load = PCT_FULL;
        hi_ok = 1'b0;
        lo_ok = 1'b0;
        hi_i = 0;
        lo_i = 0;
        for (int i = 0; i < span; i++) begin
          if (core_load[i] > hi_load) begin
            hi_load = core_load[i];
            hi_i = i;
            hi_ok = 1'b1;
          end
          if (core_load[i] < lo_load) begin
            lo_load = core_load[i];
            lo_i = i;
            lo_ok = 1'b1;
          end
        end
        need = hi_ok && lo_ok && hi_i != lo_i && hi_load >= cfg_now.high_thr &&
               lo_load <= cfg_now.low_thr;
        sel_busy = CORE_W'(hi_i);
        sel_idle = CORE_W'(lo_i);
        scan_open = need;
        top_runs = '0;
        top_tid = '0;
        top_valid = 1'b0;
        decision_q.push_back('{REPORT_EVAL, need, sel_busy, sel_idle, 1'b0, TID_W'(0)});
      end
      KIND_OFFER: begin
        if (scan_open && !excl && core == sel_busy && runs > top_runs) begin
          top_runs = runs;
          top_tid = tid;
          top_valid = 1'b1;
        end
      end
      default: begin
        if (scan_open) begin
          scan_open = 1'b0;
          decision_q.push_back('{REPORT_END, 1'b1, sel_busy, sel_idle, top_valid,
                                 top_valid ? top_tid : TID_W'(0)});
        end
      end
    endcase
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CORE_W-1:0] core,
      input logic [COUNT_W-1:0] idle, input logic [TID_W-1:0] tid,
      input logic [COUNT_W-1:0] runs, input logic excl);
    logic full_seen;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_kind       <= kind;
    in_core_index <= core;
    in_idle_count <= idle;
    in_thread_id  <= tid;
    in_run_count  <= runs;
    in_excluded   <= excl;
    do begin
      @(negedge clk);
      full_seen = in_full;
      @(posedge clk);
    end while (full_seen);
    if (cfg_now.enable) sent_count++;
    predict_decision(kind, core, idle, tid, runs, excl);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
      input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_ENABLE:   cfg_now.enable       = data[0];
      REG_ACTIVE:   cfg_now.active_cores = data[ACTIVE_W-1:0];
      REG_INTERVAL: cfg_now.interval     = data[INTERVAL_W-1:0];
      REG_HIGH:     cfg_now.high_thr     = data[PCT_W-1:0];
      REG_LOW:      cfg_now.low_thr      = data[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic en, input logic [ACTIVE_W-1:0] act,
      input logic [INTERVAL_W-1:0] intv, input logic [PCT_W-1:0] hi,
      input logic [PCT_W-1:0] lo);
    wait_drained();
    write_reg(REG_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_ACTIVE, CFG_DATA_W'(act));
    write_reg(REG_INTERVAL, CFG_DATA_W'(intv));
    write_reg(REG_HIGH, CFG_DATA_W'(hi));
    write_reg(REG_LOW, CFG_DATA_W'(lo));
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) out_pop <= rst_n && ($urandom_range(99) >= rx_idle_pct);

  logic s_live;
  logic s_empty;
  logic s_pop;
  res_t s_res;

  always @(negedge clk) begin
    s_live  = rst_n;
    s_empty = out_empty;
    s_pop   = out_pop;
    s_res   = '{out_report_kind, out_balance_needed, out_busy_core, out_idle_core,
                out_migrate, out_chosen_thread};
  end

  function automatic void compare_field(input string name, input logic [TID_W-1:0] want,
      input logic [TID_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (s_live && s_pop && !s_empty) begin
      if (decision_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %p", $time, s_res);
        errors++;
      end else begin
        want = decision_q.pop_front();
        compare_field("report_kind", want.report_kind, s_res.report_kind);
        compare_field("balance_needed", want.balance_needed, s_res.balance_needed);
        compare_field("busy_core", want.busy_core, s_res.busy_core);
        compare_field("idle_core", want.idle_core, s_res.idle_core);
        compare_field("migrate", want.migrate, s_res.migrate);
        compare_field("chosen_thread", want.chosen_thread, s_res.chosen_thread);
      end
    end
  end

  task automatic test_reset_state();
    send_item(KIND_EVAL, 3'd0, '0, '0, '0, 1'b0);
    send_item(KIND_OFFER, 3'd0, '0, 8'h12, 64'd9, 1'b0);
    send_item(KIND_END, 3'd0, '0, '0, '0, 1'b0);
  endtask

  task automatic test_load_update();
    send_item(KIND_SAMPLE, 3'd0, 64'd0, '0, '0, 1'b0);
    send_item(KIND_SAMPLE, 3'd1, 64'd100000, '0, '0, 1'b0);
    send_item(KIND_SAMPLE, 3'd2, '1, '0, '0, 1'b0);
    send_item(KIND_SAMPLE, 3'd3, 64'd99999, '0, '0, 1'b0);
    send_item(KIND_SAMPLE, 3'd4, 64'd50000, '0, '0, 1'b0);
    send_item(KIND_SAMPLE, 3'd2, 64'd0, '0, '0, 1'b0);
    send_item(KIND_EVAL, 3'd7, '1, '1, '1, 1'b1);
  endtask

  task automatic test_thread_pick();
    send_item(KIND_OFFER, 3'd0, '0, 8'hFF, 64'd5, 1'b0);
    send_item(KIND_OFFER, 3'd0, '0, 8'h11, 64'd5, 1'b0);
    send_item(KIND_OFFER, 3'd0, '0, 8'h22, '1, 1'b1);
    send_item(KIND_OFFER, 3'd1, '0, 8'h33, '1, 1'b0);
    send_item(KIND_OFFER, 3'd0, '0, 8'h00, '1, 1'b0);
    send_item(KIND_END, 3'd0, '0, '0, '0, 1'b0);
    send_item(KIND_END, 3'd0, '0, '0, '0, 1'b0);
    send_item(KIND_EVAL, 3'd0, '0, '0, '0, 1'b0);
    send_item(KIND_END, 3'd0, '0, '0, '0, 1'b0);
  endtask

  task automatic test_register_extremes();
    set_config(1'b1, 4'd8, 32'd0, 7'd75, 7'd25);
    send_item(KIND_SAMPLE, 3'd1, 64'd12345, '0, '0, 1'b0);
    set_config(1'b1, 4'd8, 32'd1, 7'd100, 7'd0);
    send_item(KIND_SAMPLE, 3'd1, 64'd12345, '0, '0, 1'b0);
    send_item(KIND_SAMPLE, 3'd5, 64'd1, '0, '0, 1'b0);
    send_item(KIND_EVAL, 3'd0, '0, '0, '0, 1'b0);
    send_item(KIND_END, 3'd0, '0, '0, '0, 1'b0);
    set_config(1'b1, 4'd0, 32'hFFFF_FFFF, 7'd0, 7'd100);
    send_item(KIND_EVAL, 3'd0, '0, '0, '0, 1'b0);
    send_item(KIND_SAMPLE, 3'd6, prev_idle[6] + 64'hFFFF_FFFE, '0, '0, 1'b0);
    set_config(1'b1, 4'd15, 32'd100000, 7'd127, 7'd127);
    send_item(KIND_EVAL, 3'd0, '0, '0, '0, 1'b0);
    set_config(1'b1, 4'd1, 32'd100000, 7'd0, 7'd100);
    send_item(KIND_EVAL, 3'd0, '0, '0, '0, 1'b0);
  endtask

  task automatic test_disabled();
    set_config(1'b0, 4'd8, 32'd100000, 7'd75, 7'd25);
    send_item(KIND_SAMPLE, 3'd0, '1, '0, '0, 1'b0);
    send_item(KIND_EVAL, 3'd0, '0, '0, '0, 1'b0);
    send_item(KIND_OFFER, 3'd0, '0, 8'h5A, '1, 1'b0);
    send_item(KIND_END, 3'd0, '0, '0, '0, 1'b0);
    set_config(1'b1, RST_ACTIVE, RST_INTERVAL, RST_HIGH_THR, RST_LOW_THR);
    send_item(KIND_EVAL, 3'd0, '0, '0, '0, 1'b0);
  endtask

  function automatic logic [COUNT_W-1:0] idle_step();
    logic [COUNT_W-1:0] reach;
    if (cfg_now.interval == 0) return rand64();
    reach = COUNT_W'(cfg_now.interval) + COUNT_W'(cfg_now.interval) / 4 + 1;
    return rand64() % reach;
  endfunction

  task automatic balance_round();
    logic [CORE_W-1:0] core;
    int                samples;
    int                offers;
    samples = $urandom_range(1, 8);
    offers  = $urandom_range(0, 6);
    repeat (samples) begin
      core = CORE_W'($urandom_range(0, CORES - 1));
      send_item(KIND_SAMPLE, core, prev_idle[core] + idle_step(), TID_W'($urandom),
                rand64(), 1'($urandom));
    end
    send_item(KIND_EVAL, CORE_W'($urandom), rand64(), TID_W'($urandom), rand64(),
              1'($urandom));
    repeat (offers) begin
      core = ($urandom_range(99) < 75) ? sel_busy : CORE_W'($urandom);
      send_item(KIND_OFFER, core, rand64(), TID_W'($urandom),
                $urandom_range(1) ? COUNT_W'($urandom_range(0, 20)) : rand64(),
                $urandom_range(99) < 20);
    end
    if ($urandom_range(99) < 90) begin
      send_item(KIND_END, CORE_W'($urandom), rand64(), TID_W'($urandom), rand64(),
                1'($urandom));
    end
  endtask

  task automatic run_phase(input int target);
    int goal;
    int halfway;
    bit paused;
    goal    = sent_count + target;
    halfway = sent_count + target / 2;
    paused  = 1'b0;
    while (sent_count < goal) begin
      if (!paused && sent_count >= halfway) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        send_item(KIND_W'($urandom), CORE_W'($urandom), rand64(), TID_W'($urandom),
                  rand64(), 1'($urandom));
      end else begin
        balance_round();
      end
    end
  endtask

  task automatic test_random_traffic();
    set_config(1'b1, 4'd8, 32'd1000, 7'd75, 7'd25);
    tx_idle_pct = 14;
    rx_idle_pct = 55;
    run_phase(150);
    set_config(1'b1, ACTIVE_W'($urandom_range(1, 15)), $urandom_range(50, 100000),
               PCT_W'($urandom_range(50, 100)), PCT_W'($urandom_range(0, 50)));
    tx_idle_pct = 55;
    rx_idle_pct = 14;
    run_phase(150);
    set_config(1'b1, ACTIVE_W'($urandom_range(2, 12)), $urandom_range(1, 5000),
               PCT_W'($urandom_range(60, 90)), PCT_W'($urandom_range(10, 40)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(150);
  endtask

  initial begin
    cfg_now = '{enable: 1'b1, active_cores: RST_ACTIVE, interval: RST_INTERVAL,
                high_thr: RST_HIGH_THR, low_thr: RST_LOW_THR};
    foreach (prev_idle[i]) begin
      prev_idle[i] = '0;
      core_load[i] = '0;
    end
    scan_open = 1'b0;
    sel_busy  = '0;
    sel_idle  = '0;
    top_runs  = '0;
    top_tid   = '0;
    top_valid = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_load_update();
    test_thread_pick();
    test_register_extremes();
    test_disabled();
    test_random_traffic();
    wait_drained();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
